/* sv/pbcd_pkg.sv */
// Shared types, constants and digit helpers for the packed BCD
// add/subtract/compare unit. No dependencies.
`default_nettype none

package pbcd_pkg;

  localparam int DIGITS  = 15;
  localparam int DIGIT_W = 4;
  localparam int MAG_W   = DIGIT_W * DIGITS;
  localparam int RES_W   = DIGIT_W * (DIGITS + 1);
  localparam int CNT_W   = 4;
  localparam int RINT_W  = 5;

  // Operation kinds (KIND_NONE is unused and yields an all-zero result)
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_SUB  = 2'd1;
  localparam logic [1:0] KIND_CMP  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Compare order codes
  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Per-digit +6 bias used by the binary-adder BCD trick
  localparam logic [RES_W-1:0] SIXES = {4'h0, {DIGITS{4'h6}}};

  typedef struct packed {
    logic [1:0]       kind;
    logic [MAG_W-1:0] left_digits;
    logic             left_negative;
    logic [CNT_W-1:0] left_int_digits;
    logic [MAG_W-1:0] right_digits;
    logic             right_negative;
    logic [CNT_W-1:0] right_int_digits;
  } in_req_t;

  typedef struct packed {
    logic [RES_W-1:0]  result_digits;
    logic              result_negative;
    logic [RINT_W-1:0] result_int_digits;
    logic              truncated;
    logic [1:0]        order;
    logic              bad_digit;
  } out_rsp_t;

  // Aligned and ordered operands handed from the align stage to the adder
  typedef struct packed {
    logic              arith;     // add/subtract result, digits are live
    logic              sub;       // take b from a (a >= b)
    logic [MAG_W-1:0]  a;
    logic [MAG_W-1:0]  b;
    logic              neg;
    logic [RINT_W-1:0] int_digits;
    logic              truncated;
    logic [1:0]        order;
    logic              bad_digit;
  } align_t;

  function automatic logic has_bad_nibble(input logic [MAG_W-1:0] v);
    logic bad;
    bad = 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (v[DIGIT_W*i +: DIGIT_W] > 4'd9) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

  function automatic logic [MAG_W-1:0] nines_comp(input logic [MAG_W-1:0] v);
    logic [MAG_W-1:0] r;
    for (int i = 0; i < DIGITS; i++) begin
      r[DIGIT_W*i +: DIGIT_W] = 4'd9 - v[DIGIT_W*i +: DIGIT_W];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/packed_bcd_add_subtract_compare_unit.sv */
// Top level of the packed BCD add/subtract/compare unit: input register,
// alignment/compare stage, decimal adder stage and result register.
// Depends on pbcd_pkg.
// Usage:
//   Requests enter on in_valid/in_ready carrying an in_req_t: two 15-digit
//   sign-magnitude packed BCD operands with integer-digit counts and a kind
//   (add, subtract, compare). Each request yields exactly one out_rsp_t on
//   out_valid/out_ready, in request order.
//   Path: an accepted request passes the input register, align register and
//   result register in that order before it is presented on out_valid.
//   Throughput: one request per cycle while out_ready is high. The pipeline
//   has three register stages; each advances when the stage after it is
//   empty or moving, so bubbles collapse and up to three requests are in flight.
//   Stalls: while out_valid is high and out_ready low, the result holds and
//   the stages behind it keep filling; in_ready drops once all three hold a
//   request.
//   Reset: rst_n (synchronous, active low) empties all stages; in_ready is
//   high in the first cycle after reset.
//   Datapath: stage 1 clamps counts, aligns, checks digits and orders the
//   magnitudes; stage 2 is a 64-bit binary add with +6 bias, then correction.
`default_nettype none

module packed_bcd_add_subtract_compare_unit
  import pbcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_rsp_t      out_data
);

  // ---------------------------------------------------------------------
  // Stage handshake: each stage loads when it is empty or being drained
  // ---------------------------------------------------------------------
  logic     s1_valid_r, s2_valid_r, out_valid_r;
  logic     s1_en, s2_en, out_en;
  in_req_t  s1_req_r;
  align_t   s2_r, s2_nxt;
  out_rsp_t out_data_r, out_nxt;

  assign out_en   = !out_valid_r || out_ready;
  assign s2_en    = !s2_valid_r || out_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= in_valid;
      if (s2_en)  s2_valid_r  <= s1_valid_r;
      if (out_en) out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_req_r <= in_data;
    end
    if (s2_en && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
    if (out_en && s2_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: digit check, alignment, magnitude order, operand selection
  // ---------------------------------------------------------------------
  logic             bad;
  logic [CNT_W-1:0] li, ri, m, shl, shr;
  logic [MAG_W-1:0] al, ar, mask_l, mask_r;
  logic             lost_l, lost_r;
  logic             mag_gt, mag_lt, mag_eq;
  logic             cmp_pos, cmp_neg;
  logic             ln, rn, ern;
  logic [1:0]       mag_ord;

  assign ln  = s1_req_r.left_negative;
  assign rn  = s1_req_r.right_negative;
  assign ern = (s1_req_r.kind == KIND_SUB) ? !rn : rn;

  assign bad = has_bad_nibble(s1_req_r.left_digits) ||
               has_bad_nibble(s1_req_r.right_digits);

  // Counts above the digit capacity behave as full capacity
  assign li = (s1_req_r.left_int_digits > CNT_W'(DIGITS)) ?
              CNT_W'(DIGITS) : s1_req_r.left_int_digits;
  assign ri = (s1_req_r.right_int_digits > CNT_W'(DIGITS)) ?
              CNT_W'(DIGITS) : s1_req_r.right_int_digits;
  assign m   = (li > ri) ? li : ri;
  assign shl = m - li;
  assign shr = m - ri;

  assign al     = s1_req_r.left_digits  >> {shl, 2'b00};
  assign ar     = s1_req_r.right_digits >> {shr, 2'b00};
  assign mask_l = ~({MAG_W{1'b1}} << {shl, 2'b00});
  assign mask_r = ~({MAG_W{1'b1}} << {shr, 2'b00});
  assign lost_l = |(s1_req_r.left_digits  & mask_l);
  assign lost_r = |(s1_req_r.right_digits & mask_r);

  // Exact order: on an aligned tie, the side that lost digits is larger
  assign mag_gt  = al > ar;
  assign mag_lt  = al < ar;
  assign mag_eq  = !mag_gt && !mag_lt;
  assign cmp_pos = mag_gt || (mag_eq && lost_l);
  assign cmp_neg = mag_lt || (mag_eq && !lost_l && lost_r);

  always_comb begin
    priority if (cmp_pos) mag_ord = ORD_GREATER;
    else if (cmp_neg)     mag_ord = ORD_LESS;
    else                  mag_ord = ORD_EQUAL;
  end

  always_comb begin
    s2_nxt            = '0;
    s2_nxt.a          = al;
    s2_nxt.b          = ar;
    if (bad && s1_req_r.kind != KIND_NONE) begin
      s2_nxt.bad_digit = 1'b1;
    end else begin
      unique case (s1_req_r.kind)
        KIND_ADD, KIND_SUB: begin
          s2_nxt.arith      = 1'b1;
          s2_nxt.int_digits = {1'b0, m} + RINT_W'(1);
          s2_nxt.truncated  = lost_l || lost_r;
          if (ln == ern) begin
            s2_nxt.neg = ln;
          end else if (cmp_pos) begin
            s2_nxt.sub = 1'b1;
            s2_nxt.neg = ln;
          end else begin
            // Smaller or equal left: right minus left, effective right sign
            s2_nxt.sub = 1'b1;
            s2_nxt.a   = ar;
            s2_nxt.b   = al;
            s2_nxt.neg = ern;
          end
        end
        KIND_CMP: begin
          if (ln != rn) begin
            s2_nxt.order = ln ? ORD_LESS : ORD_GREATER;
          end else if (ln) begin
            // Both negative: larger magnitude is the smaller number
            s2_nxt.order = ORD_GREATER - mag_ord;
          end else begin
            s2_nxt.order = mag_ord;
          end
        end
        default: begin
          s2_nxt.arith = 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: BCD add via binary add with +6 per digit. Subtraction adds the
  // nines' complement plus one; the carry out of the top digit is dropped.
  // ---------------------------------------------------------------------
  logic [MAG_W-1:0] b_op;
  logic [RES_W-1:0] a_ext, b_ext, sum, carries, digits;

  assign b_op    = s2_r.sub ? nines_comp(s2_r.b) : s2_r.b;
  assign a_ext   = {4'h0, s2_r.a};
  assign b_ext   = {4'h0, b_op} + SIXES;
  assign sum     = a_ext + b_ext + RES_W'(s2_r.sub);
  assign carries = sum ^ a_ext ^ b_ext;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      digits[DIGIT_W*i +: DIGIT_W] = carries[DIGIT_W*(i+1)] ?
        sum[DIGIT_W*i +: DIGIT_W] : sum[DIGIT_W*i +: DIGIT_W] - 4'd6;
    end
    digits[RES_W-1 -: DIGIT_W] = s2_r.sub ? 4'h0 : sum[RES_W-1 -: DIGIT_W];
  end

  always_comb begin
    out_nxt                   = '0;
    out_nxt.result_digits     = s2_r.arith ? digits : '0;
    out_nxt.result_negative   = s2_r.neg;
    out_nxt.result_int_digits = s2_r.int_digits;
    out_nxt.truncated         = s2_r.truncated;
    out_nxt.order             = s2_r.order;
    out_nxt.bad_digit         = s2_r.bad_digit;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The adder stage only ever subtracts the smaller magnitude from the larger
  a_sub_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_r.arith && s2_r.sub |-> s2_r.a >= s2_r.b)
    else $error("subtract with a < b reached the adder");

  // A bad digit blanks every other field
  a_bad_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.bad_digit |->
      out_data_r.result_digits == '0 && out_data_r.order == ORD_LESS &&
      out_data_r.result_int_digits == '0)
    else $error("bad digit result carries data");

  // Arithmetic results carry no order; the top digit is only a carry
  a_arith_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_int_digits != '0 |->
      out_data_r.order == ORD_LESS && out_data_r.result_digits[RES_W-1 -: DIGIT_W] <= 4'd1)
    else $error("arithmetic result has order or bad carry digit");

  // Non-arithmetic results leave the sign and truncation clear
  a_nonarith_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.result_int_digits == '0 |->
      !out_data_r.result_negative && !out_data_r.truncated)
    else $error("compare or blank result has sign or truncation set");

endmodule

`default_nettype wire
